// ----- rtl/assert_macros.svh -----
// assertion macros shared by the deframer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define CFD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define CFD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/cfd_pkg.sv -----
// package with constants and types of the frame deframer
package cfd_pkg;

   localparam logic [8:0] HDR_STD   = 9'd4;
   localparam logic [8:0] HDR_EXT   = 9'd6;
   localparam logic [8:0] CYC_BYTES = 9'd2;
   localparam int         BYTE_BITS = 8;

   localparam logic ITEM_DATA = 1'b0;
   localparam logic ITEM_DONE = 1'b1;

   typedef struct packed {
      logic        item_type;
      logic        is_extended;
      logic [31:0] frame_id;
      logic [7:0]  data_length;
      logic [7:0]  byte_index;
      logic [7:0]  data_byte;
      logic [15:0] cyclic_value;
   } cfd_result_type;

endpackage

// ----- rtl/cfd_if.sv -----
// valid/ready channel interfaces for received bytes and deframed results
interface cfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cfd_rsp_if;
   logic        valid;
   logic        ready;
   logic        item_type;
   logic        is_extended;
   logic [31:0] frame_id;
   logic [7:0]  data_length;
   logic [7:0]  byte_index;
   logic [7:0]  data_byte;
   logic [15:0] cyclic_value;

   modport source (output valid, output item_type, output is_extended, output frame_id,
                   output data_length, output byte_index, output data_byte,
                   output cyclic_value, input ready);
   modport sink   (input valid, input item_type, input is_extended, input frame_id,
                   input data_length, input byte_index, input data_byte,
                   input cyclic_value, output ready);
endinterface

// ----- rtl/cfd_parser.sv -----
// position-driven frame parser: state registers and per-byte decode
module cfd_parser (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  logic [7:0]              rx_byte,
   output logic                    emit,
   output cfd_pkg::cfd_result_type result
);

   logic [8:0]  pos_ff, pos_in;
   logic        ext_ff, ext_in;
   logic [31:0] id_ff, id_in;
   logic [7:0]  len_ff, len_in;
   logic [7:0]  cyc_ff, cyc_in;

   logic [8:0]  hdr;
   logic [8:0]  data_end;
   logic [8:0]  idx_full;

   always_comb begin
      hdr      = ext_ff ? cfd_pkg::HDR_EXT : cfd_pkg::HDR_STD;
      data_end = hdr + {1'b0, len_ff};
      idx_full = pos_ff - hdr;

      pos_in = pos_ff;
      ext_in = ext_ff;
      id_in  = id_ff;
      len_in = len_ff;
      cyc_in = cyc_ff;
      emit   = 1'b0;

      result.item_type    = cfd_pkg::ITEM_DATA;
      result.is_extended  = ext_ff;
      result.frame_id     = id_ff;
      result.data_length  = len_ff;
      result.byte_index   = idx_full[7:0];
      result.data_byte    = rx_byte;
      result.cyclic_value = 16'd0;

      if (pos_ff == 9'd0) begin
         ext_in = (rx_byte != 8'd0);
         id_in  = 32'd0;
         len_in = 8'd0;
         cyc_in = 8'd0;
         pos_in = 9'd1;
      end else if (pos_ff < hdr - 9'd1) begin
         id_in  = (id_ff << cfd_pkg::BYTE_BITS) | {24'd0, rx_byte};
         pos_in = pos_ff + 9'd1;
      end else if (pos_ff == hdr - 9'd1) begin
         len_in = rx_byte;
         pos_in = pos_ff + 9'd1;
      end else if (pos_ff < data_end) begin
         emit   = 1'b1;
         pos_in = pos_ff + 9'd1;
      end else if (pos_ff < data_end + cfd_pkg::CYC_BYTES - 9'd1) begin
         cyc_in = rx_byte;
         pos_in = pos_ff + 9'd1;
      end else begin
         emit                = 1'b1;
         result.item_type    = cfd_pkg::ITEM_DONE;
         result.byte_index   = 8'd0;
         result.data_byte    = 8'd0;
         result.cyclic_value = {cyc_ff, rx_byte};
         pos_in              = 9'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= 9'd0;
         ext_ff <= 1'b0;
         id_ff  <= 32'd0;
         len_ff <= 8'd0;
         cyc_ff <= 8'd0;
      end else if (step) begin
         pos_ff <= pos_in;
         ext_ff <= ext_in;
         id_ff  <= id_in;
         len_ff <= len_in;
         cyc_ff <= cyc_in;
      end
   end

endmodule

// ----- rtl/can_frame_deframer_top.sv -----
// top level of the frame deframer: input register, parser and result register
//
// req_bus carries one received serial byte per beat; rsp_bus carries one
// deframed result per beat: a data-byte result for every byte of the data
// field, and a frame-done result with identifier, format, length and the
// trailing cyclic value on the last byte of each frame. Header bytes and
// the first cyclic byte give no result.
// A byte accepted into the input register is decoded by the parser into
// the result register, which offers its result beat; while the receiver
// stalls, the byte waits in the input register. Throughput: one byte per
// cycle unless the receiver stalls, as the parser decode is combinational.
// Reset clears both stage valids and restarts the parser at byte zero.
// When the receiver stalls, the result register holds its beat; the input
// register takes one more byte only if it is empty, and req_bus.ready then
// stays low until the result beat is taken.
`include "assert_macros.svh"

module can_frame_deframer_top (
   input logic     clock,
   input logic     reset,
   cfd_req_if.sink   req_bus,
   cfd_rsp_if.source rsp_bus
);

   logic                    in_valid_ff, in_valid_in;
   logic [7:0]              in_byte_ff, in_byte_in;
   logic                    out_valid_ff, out_valid_in;
   cfd_pkg::cfd_result_type out_ff, out_in;

   logic                    advance;
   logic                    step;
   logic                    emit;
   cfd_pkg::cfd_result_type result;

   assign advance       = !out_valid_ff || rsp_bus.ready;
   assign step          = in_valid_ff && advance;
   assign req_bus.ready = !in_valid_ff || advance;

   cfd_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .rx_byte (in_byte_ff),
      .emit    (emit),
      .result  (result)
   );

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_byte_in   = in_byte_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (req_bus.ready) begin
         in_valid_in = req_bus.valid;
         in_byte_in  = req_bus.rx_byte;
      end
      if (advance) begin
         out_valid_in = step && emit;
         out_in       = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      out_ff     <= out_in;
   end

   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.item_type    = out_ff.item_type;
   assign rsp_bus.is_extended  = out_ff.is_extended;
   assign rsp_bus.frame_id     = out_ff.frame_id;
   assign rsp_bus.data_length  = out_ff.data_length;
   assign rsp_bus.byte_index   = out_ff.byte_index;
   assign rsp_bus.data_byte    = out_ff.data_byte;
   assign rsp_bus.cyclic_value = out_ff.cyclic_value;

   `CFD_ASSERT(a_stall_only_when_full, clock, reset,
      !req_bus.ready |-> (in_valid_ff && out_valid_ff), "input stalled while a stage is free")
   `CFD_ASSERT_ALWAYS(a_reset_clears, clock,
      $past(reset) |-> (!in_valid_ff && !out_valid_ff), "stage valid survived reset")
   `CFD_ASSERT(a_emit_lands, clock, reset,
      (step && emit) |=> out_valid_ff, "parser result dropped")
   `CFD_ASSERT(a_done_clean, clock, reset,
      (out_valid_ff && out_ff.item_type == cfd_pkg::ITEM_DONE) |->
      (out_ff.byte_index == 8'd0 && out_ff.data_byte == 8'd0),
      "frame-done beat carries data fields")

endmodule
